>>> src/sorted_table_binary_ternary_search_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sorted table search block
// Shared checks written once and used by the search RTL file.
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_BINARY_TERNARY_SEARCH_DEFINES_SVH
`define SORTED_TABLE_BINARY_TERNARY_SEARCH_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define STS_ASSERT_IMPL(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define STS_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> src/sts_pkg.sv
// ----------------------------------------------------------------------------
// Sorted table search package
// Action codes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none
package sts_pkg;
  localparam logic [1:0] ACT_APPEND = 2'd0;
  localparam logic [1:0] ACT_CLEAR  = 2'd1;
  localparam logic [1:0] ACT_SEARCH = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SA_RD,   // read table[a]
    ST_SB_RD,   // read table[b]
    ST_S_CMP,   // compare, maybe write b
    ST_S_WRA,   // write a
    ST_B_RD,    // binary probe read
    ST_B_CMP,
    ST_T_RD1,   // ternary probe 1 read
    ST_T_RD2,   // ternary probe 2 read
    ST_T_CMP,
    ST_DONE
  } state_t;
endpackage
`default_nettype wire

>>> src/sts_table.sv
// ----------------------------------------------------------------------------
// Sorted table search storage
// Single-port table memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module sts_table #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

>>> src/sorted_table_binary_ternary_search.sv
// ----------------------------------------------------------------------------
// Sorted table with binary and ternary search
// Appends, clears and searches a table of signed values.
// ----------------------------------------------------------------------------
// Raise start with action and value while busy is low. Append and clear
// give no result. A search first sorts the table by exchange sort if it
// was appended to since the last sort and holds more than one entry.
// Binary search then probes, and after it ternary search, each ending in
// a final bound check; done is registered from ST_DONE. Every step goes
// through the single table memory port. The result shows on the result
// ports for exactly one cycle with done high; the receiver cannot stall
// it. Values are stored as order keys (sign bit flipped) so unsigned
// comparisons serve every value compare.
`default_nettype none
`include "sorted_table_binary_ternary_search_defines.svh"
module sorted_table_binary_ternary_search
  import sts_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  action,
  input  wire logic signed [VALUE_WIDTH-1:0] value,
  output logic             done,
  output logic             binary_found,
  output logic [7:0]       binary_index,
  output logic             ternary_found,
  output logic [7:0]       ternary_index
);
  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned VW = VALUE_WIDTH;
  localparam int unsigned IW = CW + 1; // signed search bounds

  state_t state, state_next;
  logic [CW-1:0] count;
  logic          is_sorted;
  logic [VW-1:0] key;
  logic [CW-1:0] a, b;
  logic [VW-1:0] va;
  logic signed [IW-1:0] lo, hi, m1, m2;
  logic [VW-1:0] v1;
  logic          bf, tf;
  logic [AW-1:0] bpos, tpos;

  logic          we;
  logic [AW-1:0] addr;
  logic [VW-1:0] wdata, rdata;

  logic [VW-1:0] in_key;
  logic signed [IW-1:0] third, span;
  logic signed [IW-1:0] bmid;

  // Flip the sign bit so unsigned order matches signed order.
  assign in_key = unsigned'(value) ^ (VW'(1) << (VW-1));

  assign span  = hi - lo;
  // (span)/3 for nonnegative span by reciprocal multiply and correction.
  always_comb begin
    logic [2*IW+2:0] prod;
    logic [IW-1:0]   q;
    logic [IW+1:0]   r;
    prod = (2*IW+3)'(unsigned'(span)) * (2*IW+3)'(((1 << (IW+1)) + 2) / 3);
    q    = IW'(prod >> (IW+1));
    r    = (IW+2)'(unsigned'(span)) - (IW+2)'(q) * (IW+2)'(3);
    if (r >= (IW+2)'(3)) q = q + IW'(1);
    third = signed'(q);
  end
  assign bmid = (lo + hi) >>> 1;

  sts_table #(.DEPTH(TABLE_DEPTH), .WIDTH(VW)) u_table (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  assign busy = (state != ST_IDLE);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start && action == ACT_SEARCH) begin
          if (!is_sorted && count > CW'(1)) state_next = ST_SA_RD;
          else state_next = ST_B_RD;
        end
      end
      ST_SA_RD: state_next = ST_SB_RD;
      ST_SB_RD: state_next = ST_S_CMP;
      ST_S_CMP: begin
        // b already points at the next element of the row.
        if (b < count) state_next = ST_SB_RD;
        else state_next = ST_S_WRA;
      end
      ST_S_WRA: begin
        if (a + CW'(2) < count) state_next = ST_SA_RD;
        else state_next = ST_B_RD;
      end
      ST_B_RD: begin
        if (lo > hi || bf) state_next = ST_T_RD1;
        else state_next = ST_B_CMP;
      end
      ST_B_CMP: state_next = ST_B_RD;
      ST_T_RD1: begin
        if (lo > hi || tf) state_next = ST_DONE;
        else state_next = ST_T_RD2;
      end
      ST_T_RD2: state_next = ST_T_CMP;
      ST_T_CMP: state_next = ST_T_RD1;
      ST_DONE:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Memory port control.
  always_comb begin
    we = 1'b0;
    addr = AW'(count);
    wdata = in_key;
    case (state)
      ST_IDLE: begin
        we = start && action == ACT_APPEND && count < CW'(TABLE_DEPTH);
      end
      ST_SA_RD: addr = AW'(a);
      ST_SB_RD: addr = AW'(b);
      ST_S_CMP: begin
        // Swap: write old a into b, keep smaller in va.
        addr = AW'(b - CW'(1));
        wdata = va;
        we = va > rdata;
      end
      ST_S_WRA: begin
        addr = AW'(a);
        wdata = va;
        we = 1'b1;
      end
      ST_B_RD:  addr = AW'(bmid);
      ST_T_RD1: addr = AW'(lo + third);
      ST_T_RD2: addr = AW'(hi - third);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      is_sorted <= 1'b1;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= (state == ST_DONE);
      if (state == ST_IDLE && start) begin
        if (action == ACT_APPEND && count < CW'(TABLE_DEPTH)) begin
          count <= count + CW'(1);
          is_sorted <= 1'b0;
        end
        if (action == ACT_CLEAR) begin
          count <= '0;
          is_sorted <= 1'b1;
        end
      end
      if (state == ST_S_WRA && state_next == ST_B_RD) is_sorted <= 1'b1;
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        key <= in_key;
        a <= '0;
        b <= CW'(1);
        lo <= '0;
        hi <= IW'(count) - IW'(1);
        bf <= 1'b0;
        tf <= 1'b0;
        bpos <= '0;
        tpos <= '0;
      end
      ST_SB_RD: begin
        if (b == a + CW'(1)) va <= rdata; // first pass of row loads a
        b <= b + CW'(1);
      end
      ST_S_CMP: begin
        if (va > rdata) va <= rdata;
      end
      ST_S_WRA: begin
        // Advance to the next row.
        a <= a + CW'(1);
        b <= a + CW'(2);
      end
      ST_B_RD: begin
        m1 <= bmid;
        if (lo > hi || bf) begin
          lo <= '0;
          hi <= IW'(count) - IW'(1);
        end
      end
      ST_B_CMP: begin
        if (rdata == key) begin
          bf <= 1'b1;
          bpos <= AW'(m1);
        end else if (rdata > key) hi <= m1 - IW'(1);
        else lo <= m1 + IW'(1);
      end
      ST_T_RD1: begin
        m1 <= lo + third;
        m2 <= hi - third;
      end
      ST_T_RD2: v1 <= rdata;
      ST_T_CMP: begin
        if (v1 == key) begin
          tf <= 1'b1; tpos <= AW'(m1);
        end else if (rdata == key) begin
          tf <= 1'b1; tpos <= AW'(m2);
        end else if (key < v1) hi <= m1 - IW'(1);
        else if (key > rdata) lo <= m2 + IW'(1);
        else begin
          lo <= m1 + IW'(1);
          hi <= m2 - IW'(1);
        end
      end
      default: ;
    endcase
  end

  assign binary_found  = bf;
  assign binary_index  = bf ? 8'(bpos) : 8'd0;
  assign ternary_found = tf;
  assign ternary_index = tf ? 8'(tpos) : 8'd0;

  `STS_ASSERT_IMPL(a_count_max, clk, rst, 1'b1, count <= CW'(TABLE_DEPTH))
  `STS_ASSERT_NEXT(a_done_one, clk, rst, done, !done)
  `STS_ASSERT_IMPL(a_idle_nodone, clk, rst, done, state == ST_IDLE)
endmodule
`default_nettype wire
